[sv/twodo_pkg.sv]
package twodo_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int CORDIC_MAX        = 24;
	localparam int IDX_W             = 5;

	localparam logic [23:0] BACK_GAIN_RST   = 24'd137031;
	localparam logic [23:0] MIDDLE_GAIN_RST = 24'd238313;

	localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

	// 360 deg in Q.8, scaled by 2^15: top of the restoring reduction
	localparam logic [33:0] TURN_TOP = 34'd3019898880;
	localparam logic signed [18:0] TURN_DEG  = 19'sd92160;
	localparam logic signed [18:0] HALF_DEG  = 19'sd46080;
	localparam logic signed [18:0] QUART_DEG = 19'sd23040;

	localparam logic [IDX_W-1:0] RED_LAST  = 5'd3;
	localparam logic [IDX_W-1:0] MATH_LAST = 5'd12;

	typedef enum logic [0:0] {
		CFG_BACK_GAIN   = 1'b0,
		CFG_MIDDLE_GAIN = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] rotation;
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
		logic signed [31:0] back_count;
	} in_word_t;

	typedef struct packed {
		logic signed [47:0] field_x;
		logic signed [47:0] field_y;
	} out_word_t;

	typedef enum logic [2:0] {
		A_GB, A_GM, A_XH, A_XL, A_YH, A_YL
	} mul_a_t;

	typedef enum logic [1:0] {
		B_DELTA, B_COS, B_SIN
	} mul_b_t;

	typedef enum logic [2:0] {
		C_NONE, C_OFFX, C_OFFY, C_LOCAL, C_HI, C_XADD, C_XSUB, C_YADD
	} acc_op_t;

	typedef struct packed {
		logic             capture;
		logic             red_step;
		logic             fold;
		logic             cord_step;
		logic [IDX_W-1:0] cord_idx;
		mul_a_t           mul_a;
		mul_b_t           mul_b;
		acc_op_t          acc;
		logic             load;
	} cmd_t;

	// arctangent of 2^-i in Q.16 degrees
	function automatic logic signed [31:0] atan_q16(input logic [IDX_W-1:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0:  r = 32'sd2949120;
			5'd1:  r = 32'sd1740967;
			5'd2:  r = 32'sd919879;
			5'd3:  r = 32'sd466945;
			5'd4:  r = 32'sd234379;
			5'd5:  r = 32'sd117304;
			5'd6:  r = 32'sd58666;
			5'd7:  r = 32'sd29335;
			5'd8:  r = 32'sd14668;
			5'd9:  r = 32'sd7334;
			5'd10: r = 32'sd3667;
			5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;
			5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;
			5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;
			5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;
			5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;
			5'd21: r = 32'sd2;
			5'd22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

[sv/twodo_ctrl.sv]
module twodo_ctrl #(
	parameter int NSTEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output twodo_pkg::cmd_t   cmd
);
	import twodo_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RED  = 6'b000010,
		ST_FOLD = 6'b000100,
		ST_CORD = 6'b001000,
		ST_MATH = 6'b010000,
		ST_LOAD = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_a   = A_GB;
		cmd.mul_b   = B_DELTA;
		cmd.acc     = C_NONE;
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					cnt_d       = '0;
					state_d     = ST_RED;
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (cnt_q == RED_LAST) begin
					cnt_d   = '0;
					state_d = ST_FOLD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ST_CORD;
			end
			ST_CORD: begin
				cmd.cord_step = 1'b1;
				cmd.cord_idx  = cnt_q;
				if (cnt_q == IDX_W'(NSTEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_MATH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MATH: begin
				// multiply issued now, its product consumed next step
				unique case (cnt_q)
					5'd0: begin cmd.mul_a = A_GB; cmd.mul_b = B_DELTA; end
					5'd1: begin cmd.mul_a = A_GM; cmd.mul_b = B_DELTA; cmd.acc = C_OFFX; end
					5'd2: cmd.acc = C_OFFY;
					5'd3: cmd.acc = C_LOCAL;
					5'd4: begin cmd.mul_a = A_XH; cmd.mul_b = B_COS; end
					5'd5: begin cmd.mul_a = A_XL; cmd.mul_b = B_COS; cmd.acc = C_HI; end
					5'd6: begin cmd.mul_a = A_YH; cmd.mul_b = B_SIN; cmd.acc = C_XADD; end
					5'd7: begin cmd.mul_a = A_YL; cmd.mul_b = B_SIN; cmd.acc = C_HI; end
					5'd8: begin cmd.mul_a = A_YH; cmd.mul_b = B_COS; cmd.acc = C_XSUB; end
					5'd9: begin cmd.mul_a = A_YL; cmd.mul_b = B_COS; cmd.acc = C_HI; end
					5'd10: begin cmd.mul_a = A_XH; cmd.mul_b = B_SIN; cmd.acc = C_YADD; end
					5'd11: begin cmd.mul_a = A_XL; cmd.mul_b = B_SIN; cmd.acc = C_HI; end
					5'd12: cmd.acc = C_YADD;
					default: cmd.acc = C_NONE;
				endcase
				if (cnt_q == MATH_LAST) begin
					cnt_d   = '0;
					state_d = ST_LOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_LOAD: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

[sv/twodo_dp.sv]
module twodo_dp #(
	parameter int FRACTION_BITS = twodo_pkg::FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  twodo_pkg::cmd_t      cmd,
	input  twodo_pkg::in_word_t  in_data,
	input  logic                 cfg_write,
	input  logic [0:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	output twodo_pkg::out_word_t out_data
);
	import twodo_pkg::*;

	localparam int SH = 24 - FRACTION_BITS;
	localparam logic signed [64:0] RND = (65'sd1 << SH) >> 1;

	logic [23:0]        gain_b_q, gain_m_q;
	logic [31:0]        prev_rot_q;
	logic signed [31:0] delta_q, back_q;
	logic signed [32:0] lr_q;
	logic [33:0]        red_q, mod_q;
	logic signed [31:0] z_q, x_q, y_q;
	logic               neg_q;
	logic signed [64:0] prod_q, phi_q;
	logic [47:0]        acc_x_q, acc_y_q, prev_x_q, prev_y_q, dx_q, dy_q, pos_x_q, pos_y_q;
	out_word_t          out_q;

	logic [33:0]        red_v, mod_v;
	logic signed [18:0] r0, r1, r2;
	logic               ng;
	logic signed [31:0] xs, ys, at, cos_v, sin_v;
	logic signed [32:0] ma;
	logic signed [31:0] mb;
	logic signed [64:0] prod_d, off_w, term_w;
	logic [47:0]        off_v, term_v, cur_x, cur_y;

	assign out_data = out_q;

	// four restoring subtract steps per cycle
	always_comb begin
		red_v = red_q;
		mod_v = mod_q;
		for (int i = 0; i < 4; i++) begin
			if (red_v >= mod_v)
				red_v = red_v - mod_v;
			mod_v = mod_v >> 1;
		end
	end

	// wrap into [-180,180), fold into [-90,90]
	always_comb begin
		r0 = $signed({2'b00, red_q[16:0]});
		r1 = (r0 >= HALF_DEG) ? r0 - TURN_DEG : r0;
		ng = 1'b0;
		r2 = r1;
		if (r1 > QUART_DEG) begin
			r2 = r1 - HALF_DEG;
			ng = 1'b1;
		end else if (r1 < -QUART_DEG) begin
			r2 = r1 + HALF_DEG;
			ng = 1'b1;
		end
	end

	assign xs    = x_q >>> cmd.cord_idx;
	assign ys    = y_q >>> cmd.cord_idx;
	assign at    = atan_q16(cmd.cord_idx);
	assign cos_v = neg_q ? -x_q : x_q;
	assign sin_v = neg_q ? -y_q : y_q;

	always_comb begin
		unique case (cmd.mul_a)
			A_GB:    ma = $signed({9'd0, gain_b_q});
			A_GM:    ma = $signed({9'd0, gain_m_q});
			A_XH:    ma = $signed({dx_q[47], dx_q[47:16]});
			A_XL:    ma = $signed({17'd0, dx_q[15:0]});
			A_YH:    ma = $signed({dy_q[47], dy_q[47:16]});
			A_YL:    ma = $signed({17'd0, dy_q[15:0]});
			default: ma = '0;
		endcase
		unique case (cmd.mul_b)
			B_DELTA: mb = delta_q;
			B_COS:   mb = cos_v;
			B_SIN:   mb = sin_v;
			default: mb = '0;
		endcase
	end

	assign prod_d = ma * mb;
	assign off_w  = (prod_q + RND) >>> SH;
	assign off_v  = off_w[47:0];
	assign term_w = (phi_q + 65'sd8192 + (prod_q >>> 16)) >>> 14;
	assign term_v = term_w[47:0];
	assign cur_y  = ({{15{lr_q[32]}}, lr_q} << (FRACTION_BITS - 1)) + acc_y_q;
	assign cur_x  = ({{16{back_q[31]}}, back_q} << FRACTION_BITS) - acc_x_q;

	// state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_b_q   <= BACK_GAIN_RST;
			gain_m_q   <= MIDDLE_GAIN_RST;
			prev_rot_q <= '0;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_BACK_GAIN:   gain_b_q <= cfg_data;
					CFG_MIDDLE_GAIN: gain_m_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.capture)
				prev_rot_q <= in_data.rotation;
			unique case (cmd.acc)
				C_OFFX: acc_x_q <= acc_x_q + off_v;
				C_OFFY: acc_y_q <= acc_y_q + off_v;
				C_LOCAL: begin
					prev_x_q <= cur_x;
					prev_y_q <= cur_y;
				end
				C_XADD: pos_x_q <= pos_x_q + term_v;
				C_XSUB: pos_x_q <= pos_x_q - term_v;
				C_YADD: pos_y_q <= pos_y_q + term_v;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.capture) begin
			delta_q <= in_data.rotation - $signed(prev_rot_q);
			lr_q    <= {in_data.right_count[31], in_data.right_count}
				- {in_data.left_count[31], in_data.left_count};
			back_q  <= in_data.back_count;
			red_q   <= in_data.rotation[31]
				? {{2{in_data.rotation[31]}}, in_data.rotation} + TURN_TOP
				: {2'b00, in_data.rotation};
			mod_q   <= TURN_TOP;
		end
		if (cmd.red_step) begin
			red_q <= red_v;
			mod_q <= mod_v;
		end
		if (cmd.fold) begin
			z_q   <= {{5{r2[18]}}, r2, 8'd0};
			x_q   <= CORDIC_K;
			y_q   <= '0;
			neg_q <= ng;
		end
		if (cmd.cord_step) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
		if (cmd.acc == C_LOCAL) begin
			dx_q <= cur_x - prev_x_q;
			dy_q <= cur_y - prev_y_q;
		end
		if (cmd.acc == C_HI)
			phi_q <= prod_q;
		if (cmd.load) begin
			out_q.field_x <= pos_x_q;
			out_q.field_y <= pos_y_q;
		end
	end

endmodule

[sv/tracking_wheel_odometry_unit.sv]
// Flow: an accepted word passes heading reduction, a fold, the CORDIC iterations (steps cap at 24),
//   13 multiply steps and an output load before it shows on out_valid; the load waits while an
//   earlier result is still held by out_stall.
// One word at a time: no new word is taken until the last one is loaded, set by the single
//   iterative CORDIC and the one shared 33x32 multiplier used ten times.
// Reset: arst_n clears position, offsets and history to zero and restores the turn gains.
module tracking_wheel_odometry_unit #(
	parameter int FRACTION_BITS = twodo_pkg::FRACTION_BITS_DEF,
	parameter int CORDIC_STEPS  = twodo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  twodo_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output twodo_pkg::out_word_t out_data,
	input  logic                 cfg_write,
	input  logic [0:0]           cfg_index,
	input  logic [23:0]          cfg_data
);
	import twodo_pkg::*;

	// steps beyond the arctangent table add nothing
	localparam int NSTEPS = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;

	cmd_t cmd;

	// sequencer: reduction, fold, CORDIC, then multiply/accumulate schedule and output load
	twodo_ctrl #(
		.NSTEPS(NSTEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	// datapath: gains, offsets, local travel, heading reduction, CORDIC, shared multiplier,
	// position and the output register that decouples the result side
	twodo_dp #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

	// a taken word keeps the input side closed while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after accepting a word");

	// a new result only appears at the end of the work on a word
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	// at most one word in flight: no accept while the sequencer is busy
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && !in_stall) |-> in_stall)
		else $error("second word accepted during work");

endmodule

[dv/tb_tracking_wheel_odometry_unit.sv]
`timescale 1ns / 100ps

module tb_tracking_wheel_odometry_unit;
	import twodo_pkg::*;

	localparam longint M48 = 64'hFFFF_FFFF_FFFF;
	localparam longint S48 = 64'h8000_0000_0000;
	localparam longint M32 = 64'hFFFF_FFFF;
	localparam int STEPS = CORDIC_STEPS_DEF;
	// settle time before a gain write: full pipeline depth plus margin
	localparam int DRAIN = STEPS + 40;

	// arctan(2^-i), Q.16 degrees
	localparam longint ARCTAN[24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t pos;
	} drill_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;
	logic      cfg_write;
	logic [0:0] cfg_index;
	logic [23:0] cfg_data;

	tracking_wheel_odometry_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block: gains and odometry state
	longint gain_back, gain_mid;
	longint last_rot, last_lx, last_ly, turn_x, turn_y, fld_x, fld_y;

	out_word_t pos_q[$];   // field positions still owed by the block
	int errors;
	bit quiet;             // end of run: no idling on either side
	bit hold_req;          // ask the receiver for one long hold

	always #5 clk = ~clk;

	function automatic longint sx48(longint v);
		return ((v & M48) ^ S48) - S48;
	endfunction

	function automatic longint sx32(longint v);
		return ((v & M32) ^ 64'h8000_0000) - 64'h8000_0000;
	endfunction

	// value(Q.16) * trig(Q.30), rounded half up
	function automatic longint trig_mul(longint a, longint c);
		longint ah, al;
		ah = a >>> 16;
		al = a - ah * 65536;
		return ((ah * c) + 8192 + ((al * c) >>> 16)) >>> 14;
	endfunction

	function automatic out_word_t odo_advance(in_word_t w);
		longint rot, delta, cur_x, cur_y, dx, dy, r, cx, cy, z, xs, ys, gdx, gdy;
		bit flip;
		out_word_t o;
		rot   = longint'(w.rotation);
		delta = sx32(rot - last_rot);
		// turn compensation: Q.16 gain * Q.8 degrees, back to Q.16
		turn_x = (turn_x + ((gain_back * delta + 128) >>> 8)) & M48;
		turn_y = (turn_y + ((gain_mid * delta + 128) >>> 8)) & M48;
		cur_y = ((longint'(w.right_count) - longint'(w.left_count)) * 32768 + turn_y) & M48;
		cur_x = (longint'(w.back_count) * 65536 - turn_x) & M48;
		dy = sx48(cur_y - last_ly);
		dx = sx48(cur_x - last_lx);
		// heading into [-180,180), then folded into [-90,90]
		r = rot % 92160;
		if (r < 0) r += 92160;
		if (r >= 46080) r -= 92160;
		flip = 0;
		if (r > 23040) begin
			r -= 46080;
			flip = 1;
		end else if (r < -23040) begin
			r += 46080;
			flip = 1;
		end
		z = r * 256;
		cx = CORDIC_K;
		cy = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (z >= 0) begin
				cx -= ys; cy += xs; z -= ARCTAN[i];
			end else begin
				cx += ys; cy -= xs; z += ARCTAN[i];
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		gdy = trig_mul(dy, cx) + trig_mul(dx, cy);
		gdx = trig_mul(dx, cx) - trig_mul(dy, cy);
		fld_y = (fld_y + gdy) & M48;
		fld_x = (fld_x + gdx) & M48;
		last_lx  = cur_x;
		last_ly  = cur_y;
		last_rot = rot & M32;
		o.field_x = fld_x[47:0];
		o.field_y = fld_y[47:0];
		return o;
	endfunction

	// Sender. Leaves in_valid high at the accepting edge; the next call
	// either lowers it for a gap or puts the next word on the bus.
	task automatic offer(in_word_t w, bit typed, out_word_t typed_pos);
		out_word_t p;
		bit took;
		p = odo_advance(w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		pos_q.push_back(typed ? typed_pos : p);
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic set_gain(cfg_idx_t idx, logic [23:0] v);
		in_valid <= 1'b0;
		wait (pos_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_BACK_GAIN) gain_back = longint'(v);
		else gain_mid = longint'(v);
	endtask

	// Receiver idling. Stall only changes at the rising edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// long hold: the block fills and must back-pressure the sender
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 0;
				out_stall <= 1'b0;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 19) == 0)
					repeat (50) @(posedge clk);   // calm stretch, stall stays low
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5) - 1) @(posedge clk);
			end
		end
	end

	// Output check. Stall and valid are stable at the falling edge, so a
	// word seen here is the one taken at the next rising edge.
	always @(negedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pos_q.size() == 0) begin
				$display("%0t: unexpected word x=%h y=%h", $time, out_data.field_x,
					out_data.field_y);
				errors++;
			end else begin
				want = pos_q.pop_front();
				if (out_data.field_x !== want.field_x) begin
					$display("%0t: field_x expected %h actual %h", $time, want.field_x,
						out_data.field_x);
					errors++;
				end
				if (out_data.field_y !== want.field_y) begin
					$display("%0t: field_y expected %h actual %h", $time, want.field_y,
						out_data.field_y);
					errors++;
				end
			end
		end
	end

	// Stimulus: directed table, then random phases over several gain settings.
	initial begin
		drill_t drill[$];
		in_word_t w;
		out_word_t none;
		logic [23:0] gb, gm;
		longint rot, lc, rc, bc;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		quiet = 0;
		hold_req = 0;
		none = '0;
		gain_back = BACK_GAIN_RST;
		gain_mid  = MIDDLE_GAIN_RST;
		last_rot = 0; last_lx = 0; last_ly = 0;
		turn_x = 0; turn_y = 0; fld_x = 0; fld_y = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rotation, left, right, back; zero rows right after reset stay at origin
		drill.push_back('{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, '0});
		drill.push_back('{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, '0});
		drill.push_back('{'{32'sd0, 32'sd0, 32'sd2, 32'sd0}, 0, '0});
		drill.push_back('{'{32'sd0, -32'sd1, 32'sd2, 32'sd1}, 0, '0});
		drill.push_back('{'{32'sd23040, 32'sd5, 32'sd9, 32'sd3}, 0, '0});   // +90 deg
		drill.push_back('{'{32'sd23041, 32'sd5, 32'sd20, 32'sd3}, 0, '0});  // just past, folds
		drill.push_back('{'{-32'sd23040, 32'sd5, 32'sd30, -32'sd3}, 0, '0});
		drill.push_back('{'{32'sd46080, 32'sd0, 32'sd40, 32'sd0}, 0, '0});  // 180 wraps to -180
		drill.push_back('{'{-32'sd46080, 32'sd0, 32'sd50, 32'sd7}, 0, '0});
		drill.push_back('{'{32'sd276580, 32'sd9, 32'sd60, 32'sd7}, 0, '0}); // several turns
		// big rotation jumps: heading delta wraps at 32 bits
		drill.push_back('{'{32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sd0}, 0, '0});
		drill.push_back('{'{32'sh80000000, 32'sd0, 32'sd0, 32'sd0}, 0, '0});
		drill.push_back('{'{32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sd0}, 0, '0});
		// count extremes; position and offsets wrap at 48 bits
		drill.push_back('{'{32'sd100, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, '0});
		drill.push_back('{'{32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000}, 0, '0});
		drill.push_back('{'{32'sd100, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, '0});
		drill.push_back('{'{32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000}, 0, '0});
		drill.push_back('{'{-32'sd1, -32'sd1, -32'sd1, -32'sd1}, 0, '0});
		drill.push_back('{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 0, '0});
		foreach (drill[i])
			offer(drill[i].w, drill[i].typed, drill[i].pos);

		rot = 0; lc = 0; rc = 0; bc = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin gb = 24'd0; gm = 24'd0; end
				2: begin gb = 24'hFFFFFF; gm = 24'hFFFFFF; end
				3: begin gb = 24'hFFFFFF; gm = 24'd0; end
				4: begin
					gb = 24'($urandom_range(0, 24'hFFFFFF));
					gm = 24'($urandom_range(0, 24'hFFFFFF));
				end
				default: begin gb = BACK_GAIN_RST; gm = MIDDLE_GAIN_RST; end
			endcase
			if (ph != 0) begin
				set_gain(CFG_BACK_GAIN, gb);
				set_gain(CFG_MIDDLE_GAIN, gm);
			end
			quiet = (ph == 5);
			for (int n = 0; n < 220; n++) begin
				if (ph == 2 && n == 40) hold_req = 1;
				if (ph == 3 && n == 100) begin
					// sender pause until the block is drained
					in_valid <= 1'b0;
					wait (pos_q.size() == 0);
					@(posedge clk);
				end
				if ($urandom_range(0, 9) == 0) begin
					// noise: any value in any field
					w.rotation    = $urandom;
					w.left_count  = $urandom;
					w.right_count = $urandom;
					w.back_count  = $urandom;
				end else begin
					// driving: small smooth steps in heading and wheel travel
					rot += $signed($urandom_range(0, 4000)) - 2000;
					lc  += $signed($urandom_range(0, 600)) - 200;
					rc  += $signed($urandom_range(0, 600)) - 200;
					bc  += $signed($urandom_range(0, 200)) - 100;
					w.rotation    = rot[31:0];
					w.left_count  = lc[31:0];
					w.right_count = rc[31:0];
					w.back_count  = bc[31:0];
				end
				offer(w, 0, none);
			end
		end
		in_valid <= 1'b0;
		wait (pos_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hang guard
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[tracking_wheel_odometry_unit.f]
sv/twodo_pkg.sv
sv/twodo_ctrl.sv
sv/twodo_dp.sv
sv/tracking_wheel_odometry_unit.sv
dv/tb_tracking_wheel_odometry_unit.sv
